>>> rtl/rcv_pkg.sv
// ============================================================================
// rcv_pkg - shared types and constants for the row contrast visibility block
// Field widths, register codes, reset values and the pixel test helpers.
// ============================================================================
package rcv_pkg;

    // Field widths
    localparam int PIXEL_W    = 8;
    localparam int ROW_OUT_W  = 12;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int Q8_W       = 24;
    localparam int Q8_FRAC    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Smallest usable frame dimension
    localparam int MIN_DIM = 3;

    // d/m >= 0.05 is tested as 20*d >= m
    localparam int CONTRAST_GAIN = 20;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_LEFT_TOP     = 3'd2,
        REG_LEFT_SLOPE   = 3'd3,
        REG_RIGHT_TOP    = 3'd4,
        REG_RIGHT_SLOPE  = 3'd5
    } cfg_reg_t;

    // Register reset values
    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [Q8_W-1:0] LEFT_TOP_RST     = 24'd0;
    localparam logic [Q8_W-1:0] LEFT_SLOPE_RST   = 24'd0;
    localparam logic [Q8_W-1:0] RIGHT_TOP_RST    = 24'd163840;
    localparam logic [Q8_W-1:0] RIGHT_SLOPE_RST  = 24'd0;

    // Configuration register file contents (Q.8 fields are two's complement)
    typedef struct packed {
        logic [FW_W-1:0] frame_width;
        logic [FH_W-1:0] frame_height;
        logic [Q8_W-1:0] left_col_at_top;
        logic [Q8_W-1:0] left_slope;
        logic [Q8_W-1:0] right_col_at_top;
        logic [Q8_W-1:0] right_slope;
    } cfg_t;

    // Absolute difference of two pixels
    function automatic logic [PIXEL_W-1:0] absdiff(input logic [PIXEL_W-1:0] a,
                                                   input logic [PIXEL_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Larger of two pixels
    function automatic logic [PIXEL_W-1:0] max_px(input logic [PIXEL_W-1:0] a,
                                                  input logic [PIXEL_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/rcv_ifs.sv
// ============================================================================
// rcv_ifs - channel interfaces of the row contrast visibility block
// Pixel input stream, result output stream and configuration write channel.
// ============================================================================

// Pixel stream, one grey value per beat
interface rcv_pixel_if;
    import rcv_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// Result stream, one row number per frame
interface rcv_result_if;
    import rcv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ROW_OUT_W-1:0] visibility_row;

    modport source (output valid, output visibility_row, input ready);
    modport sink   (input valid, input visibility_row, output ready);
endinterface

// Configuration writes, one register per beat
interface rcv_cfg_if;
    import rcv_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/rcv_ram.sv
// ============================================================================
// rcv_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module rcv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/rcv_bound.sv
// ============================================================================
// rcv_bound - boundary column of one road line for a given row
// bound = floor((col_at_top + (row - 1) * slope) / 256), two register stages.
// ============================================================================
module rcv_bound #(
    parameter int ROW_W = 12
) (
    input  logic                                     clk,
    input  logic [ROW_W-1:0]                         row,
    input  logic [rcv_pkg::Q8_W-1:0]                 col_at_top,
    input  logic [rcv_pkg::Q8_W-1:0]                 slope,
    output logic signed [ROW_W+rcv_pkg::Q8_W+1-rcv_pkg::Q8_FRAC:0] bound
);
    import rcv_pkg::*;

    localparam int PROD_W = ROW_W + 1 + Q8_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int BND_W  = SUM_W - Q8_FRAC;

    logic signed [ROW_W:0]    row_m1;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum;
    logic signed [BND_W-1:0]  bound_reg;

    // Row index of the judged row is one above the counter
    assign row_m1 = $signed({1'b0, row}) - $signed((ROW_W+1)'(1));

    // Stage 1: offset along the line
    always_ff @(posedge clk)
    begin
        prod_reg <= row_m1 * $signed(slope);
    end

    // Stage 2: add intercept, floor to whole columns
    assign sum = SUM_W'(prod_reg) + SUM_W'($signed(col_at_top));

    always_ff @(posedge clk)
    begin
        bound_reg <= BND_W'(sum >>> Q8_FRAC);
    end

    assign bound = bound_reg;

endmodule

>>> rtl/rcv_regs.sv
// ============================================================================
// rcv_regs - configuration register file
// Takes register writes and holds pixel input off while a write is presented
// and while the boundary pipeline settles after it.
// ============================================================================
module rcv_regs (
    input  logic           clk,
    input  logic           rst_n,
    rcv_cfg_if.sink        cfg,
    output rcv_pkg::cfg_t  regs,
    output logic           busy
);
    import rcv_pkg::*;

    // Cycles for the boundary pipeline to see new values
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    cfg_t       regs_reg;
    logic [1:0] settle_reg;
    logic       wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.frame_width      <= FRAME_WIDTH_RST;
            regs_reg.frame_height     <= FRAME_HEIGHT_RST;
            regs_reg.left_col_at_top  <= LEFT_TOP_RST;
            regs_reg.left_slope       <= LEFT_SLOPE_RST;
            regs_reg.right_col_at_top <= RIGHT_TOP_RST;
            regs_reg.right_slope      <= RIGHT_SLOPE_RST;
        end
        else if (wr)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:  regs_reg.frame_width      <= cfg.data[FW_W-1:0];
                REG_FRAME_HEIGHT: regs_reg.frame_height     <= cfg.data[FH_W-1:0];
                REG_LEFT_TOP:     regs_reg.left_col_at_top  <= cfg.data[Q8_W-1:0];
                REG_LEFT_SLOPE:   regs_reg.left_slope       <= cfg.data[Q8_W-1:0];
                REG_RIGHT_TOP:    regs_reg.right_col_at_top <= cfg.data[Q8_W-1:0];
                REG_RIGHT_SLOPE:  regs_reg.right_slope      <= cfg.data[Q8_W-1:0];
                default:          regs_reg                  <= regs_reg;
            endcase
        end
    end

    // Settle counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= '0;
        end
        else if (wr)
        begin
            settle_reg <= SETTLE_CYCLES;
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    assign regs = regs_reg;
    assign busy = cfg.valid || (settle_reg != '0);

endmodule

>>> rtl/row_contrast_visibility.sv
// ============================================================================
// row_contrast_visibility - lowest row without local contrast in a frame
// Streams grey pixels in raster order and reports one row number per frame.
// ============================================================================
// Usage:
//   pixels  : one 8-bit grey value per beat, raster order, row 0 first.
//   results : one visibility_row beat after the last pixel of each frame;
//             it is the greatest row in 1..height-2 with no contrasted pixel
//             inside the road span, or 0 if every such row has one.
//   cfg     : register writes (width, height, Q.8 boundary lines); always
//             ready. Pixel input is held off while a write is presented and
//             while the boundary multipliers settle after it.
// Throughput: one pixel per cycle when input is not held off, limited by the
//   single write port of the line buffer RAM (one read and one write per pixel).
// Result path: the last pixel is taken into the input register with its line
//   buffer read, then the pixel test and row bookkeeping load the result
//   register, unless an earlier result is still held there and not taken.
// Stall: a pending result waits in the output register; pixels keep flowing
//   until the next frame end reaches the test stage while it is still held.
// Reset: counters, row state and registers go to their reset values at once;
//   the line buffers are not cleared, every entry is written before use.
// ============================================================================
module row_contrast_visibility #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    rcv_pixel_if.sink    pixels,
    rcv_result_if.source results,
    rcv_cfg_if.sink      cfg
);
    import rcv_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int BND_W = ROW_W + Q8_W + 2 - Q8_FRAC;
    localparam int CMP_W = (BND_W > COL_W + 1) ? BND_W : COL_W + 1;
    localparam int SCL_W = PIXEL_W + 5;
    localparam int NB_N  = 4;

    cfg_t regs;
    logic cfg_busy;

    // Register file
    rcv_regs u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs),
        .busy  (cfg_busy)
    );

    // Clamped frame geometry, kept as last index
    logic [31:0]      fw32;
    logic [31:0]      fh32;
    logic [COL_W-1:0] w_m1;
    logic [ROW_W-1:0] h_m1;

    assign fw32 = 32'(regs.frame_width);
    assign fh32 = 32'(regs.frame_height);

    always_comb
    begin
        if (fw32 < 32'(MIN_DIM))
        begin
            w_m1 = COL_W'(MIN_DIM - 1);
        end
        else if (fw32 > 32'(MAX_WIDTH))
        begin
            w_m1 = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            w_m1 = COL_W'(fw32 - 32'd1);
        end

        if (fh32 < 32'(MIN_DIM))
        begin
            h_m1 = ROW_W'(MIN_DIM - 1);
        end
        else if (fh32 > 32'(MAX_HEIGHT))
        begin
            h_m1 = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            h_m1 = ROW_W'(fh32 - 32'd1);
        end
    end

    // ---------------------------------------------------------------
    // Input stage: raster counters, line buffer read
    // ---------------------------------------------------------------
    logic             in_acc;
    logic             acc_row_end;
    logic             acc_frame_end;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;

    logic               s1_valid_reg;
    logic [PIXEL_W-1:0] s1_pixel_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic               s1_adv;

    assign in_acc        = pixels.valid && pixels.ready;
    assign acc_row_end   = col_reg >= w_m1;
    assign acc_frame_end = row_reg >= h_m1;
    assign pixels.ready  = !cfg_busy && (!s1_valid_reg || s1_adv);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (acc_row_end)
            begin
                col_next = '0;
                row_next = acc_frame_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage 1 holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pixel_reg <= pixels.pixel;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
        end
    end

    // Line buffers: upper row in [15:8], middle row in [7:0]
    logic                   ram_we;
    logic [2*PIXEL_W-1:0]   ram_wdata;
    logic [2*PIXEL_W-1:0]   ram_rdata;
    logic [PIXEL_W-1:0]     up;
    logic [PIXEL_W-1:0]     mid;

    assign up        = ram_rdata[2*PIXEL_W-1:PIXEL_W];
    assign mid       = ram_rdata[PIXEL_W-1:0];
    assign ram_we    = s1_adv;
    assign ram_wdata = {mid, s1_pixel_reg};

    rcv_ram #(
        .WIDTH (2 * PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_col_reg),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Road span bounds, following the row retired by stage 1
    // ---------------------------------------------------------------
    logic [ROW_W-1:0]        bound_row_reg;
    logic signed [BND_W-1:0] lb;
    logic signed [BND_W-1:0] rb;

    rcv_bound #(.ROW_W(ROW_W)) u_left (
        .clk        (clk),
        .row        (bound_row_reg),
        .col_at_top (regs.left_col_at_top),
        .slope      (regs.left_slope),
        .bound      (lb)
    );

    rcv_bound #(.ROW_W(ROW_W)) u_right (
        .clk        (clk),
        .row        (bound_row_reg),
        .col_at_top (regs.right_col_at_top),
        .slope      (regs.right_slope),
        .bound      (rb)
    );

    // ---------------------------------------------------------------
    // Stage 1: neighborhood test and row bookkeeping
    // ---------------------------------------------------------------
    logic [PIXEL_W-1:0] pw0_reg;     // middle row, col-1 (center)
    logic [PIXEL_W-1:0] pw1_reg;     // middle row, col-2
    logic [PIXEL_W-1:0] pw2_reg;     // current row, col-1
    logic [PIXEL_W-1:0] upper_prev_reg;
    logic               contrasted_reg;
    logic [ROW_W-1:0]   best_reg;
    logic               out_valid_reg;
    logic [ROW_OUT_W-1:0] out_row_reg;

    logic               s1_row_end;
    logic               s1_frame_end;
    logic [COL_W-1:0]   j;
    logic signed [CMP_W-1:0] j_s;
    logic               in_span;
    logic               judge_en;
    logic [PIXEL_W-1:0] nb [NB_N];
    logic [PIXEL_W-1:0] d;
    logic [PIXEL_W-1:0] m;
    logic [SCL_W-1:0]   d_scaled;
    logic               hit;
    logic               contrasted_now;
    logic [ROW_W-1:0]   best_cand;

    assign s1_row_end   = s1_col_reg >= w_m1;
    assign s1_frame_end = s1_row_end && (s1_row_reg >= h_m1);
    assign s1_adv       = s1_valid_reg
                          && (!s1_frame_end || !out_valid_reg || results.ready);

    // Span check for the center column
    assign j        = s1_col_reg - COL_W'(1);
    assign j_s      = $signed(CMP_W'({1'b0, j}));
    assign in_span  = (j_s >= CMP_W'(lb)) && (j_s < CMP_W'(rb));
    assign judge_en = (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2))
                      && (s1_col_reg <= w_m1) && in_span;

    // Max difference and max value over the four neighbors
    assign nb[0] = pw1_reg;
    assign nb[1] = mid;
    assign nb[2] = upper_prev_reg;
    assign nb[3] = pw2_reg;

    always_comb
    begin
        d = '0;
        m = pw0_reg;
        for (int k = 0; k < NB_N; k++)
        begin
            d = max_px(d, absdiff(pw0_reg, nb[k]));
            m = max_px(m, nb[k]);
        end
    end

    assign d_scaled       = SCL_W'(d) * SCL_W'(CONTRAST_GAIN);
    assign hit            = judge_en && (m != '0) && (d_scaled >= SCL_W'(m));
    assign contrasted_now = ((s1_col_reg == '0) ? 1'b0 : contrasted_reg) || hit;

    // Row passes when nothing in it was contrasted
    always_comb
    begin
        best_cand = best_reg;
        if ((s1_row_reg >= ROW_W'(2)) && !contrasted_now)
        begin
            best_cand = s1_row_reg - ROW_W'(1);
        end
    end

    // Window and row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw0_reg        <= '0;
            pw1_reg        <= '0;
            pw2_reg        <= '0;
            upper_prev_reg <= '0;
            contrasted_reg <= 1'b0;
            best_reg       <= '0;
            bound_row_reg  <= '0;
        end
        else if (s1_adv)
        begin
            upper_prev_reg <= up;
            pw1_reg        <= pw0_reg;
            pw0_reg        <= mid;
            pw2_reg        <= s1_pixel_reg;
            contrasted_reg <= contrasted_now;
            if (s1_row_end)
            begin
                if (s1_frame_end)
                begin
                    best_reg      <= '0;
                    bound_row_reg <= '0;
                end
                else
                begin
                    best_reg      <= best_cand;
                    bound_row_reg <= s1_row_reg + ROW_W'(1);
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv && s1_frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_frame_end)
        begin
            out_row_reg <= ROW_OUT_W'(best_cand);
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.visibility_row = out_row_reg;

`ifndef NO_ASSERTIONS
    // Line buffer write and read never hit the same column in one cycle
    a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && in_acc) |-> (s1_col_reg != col_reg))
        else $error("line buffer read and write address collide");

    // No pixel is taken while configuration is being written or settling
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_busy |-> !pixels.ready)
        else $error("pixel accepted during configuration settle");

    // A result appears only from a frame end leaving the test stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && s1_frame_end))
        else $error("result without frame end");

    // Column counter wraps at the row end
    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && acc_row_end) |=> (col_reg == '0))
        else $error("column counter did not wrap");

    // Frame end clears the row state for the next frame
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_frame_end) |=> (best_reg == '0 && bound_row_reg == '0))
        else $error("row state not cleared at frame end");
`endif

endmodule
